// ===== sv/sad_pkg.sv =====
package sad_pkg;

  // field widths
  localparam int V_BITS         = 32;
  localparam int FACT_BITS      = 31;
  localparam int COEF_BITS      = 32;
  localparam int OUT_BITS       = 32;

  // direction reduction
  localparam int DIFF_BITS      = V_BITS + 1;
  localparam int DIR_LIMIT_BITS = 20;
  localparam int D_BITS         = DIR_LIMIT_BITS + 1;
  localparam int MAX_SHIFT      = DIFF_BITS - DIR_LIMIT_BITS;
  localparam int SHIFT_BITS     = $clog2(MAX_SHIFT + 1);

  // projection datapath
  localparam int PVD_BITS       = V_BITS + D_BITS;
  localparam int VD_BITS        = PVD_BITS + 1;
  localparam int NUM_BITS       = VD_BITS - 1;
  localparam int PDD_BITS       = 2 * D_BITS;
  localparam int DD_BITS        = 2 * DIR_LIMIT_BITS + 2;
  localparam int PT_BITS        = V_BITS + 4;
  localparam int RS_BITS        = DD_BITS + 1;
  localparam int RD_BITS        = RS_BITS + D_BITS - 1;
  localparam int RDMAG_BITS     = RD_BITS - 1;
  localparam int Q2_BITS        = DIR_LIMIT_BITS;

  // force datapath
  localparam int CN_BITS        = COEF_BITS + FACT_BITS;
  localparam int C_LO_BITS      = 32;
  localparam int C_HI_BITS      = CN_BITS - C_LO_BITS;
  localparam int P_LO_BITS      = 18;
  localparam int P_HI_BITS      = PT_BITS - P_LO_BITS;
  localparam int PP_HH_BITS     = C_HI_BITS + P_HI_BITS;
  localparam int PP_HL_BITS     = C_HI_BITS + P_LO_BITS + 1;
  localparam int PP_LH_BITS     = C_LO_BITS + 1 + P_HI_BITS;
  localparam int PP_LL_BITS     = C_LO_BITS + P_LO_BITS;
  localparam int ACC_BITS       = CN_BITS + PT_BITS + 1;

  // queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_BITS   = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_DRAG  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TANGENT_DRAG = 1'b1;

  typedef struct packed {
    logic [V_BITS-1:0]    vel_x;
    logic [V_BITS-1:0]    vel_y;
    logic [V_BITS-1:0]    vel_z;
    logic [V_BITS-1:0]    pos_a_x;
    logic [V_BITS-1:0]    pos_a_y;
    logic [V_BITS-1:0]    pos_a_z;
    logic [V_BITS-1:0]    pos_b_x;
    logic [V_BITS-1:0]    pos_b_y;
    logic [V_BITS-1:0]    pos_b_z;
    logic [FACT_BITS-1:0] area_factor;
    logic [FACT_BITS-1:0] length_factor;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] force_x;
    logic [OUT_BITS-1:0] force_y;
    logic [OUT_BITS-1:0] force_z;
    logic                zero_length;
  } out_item_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] normal;
    logic [COEF_BITS-1:0] tangent;
  } coef_t;

  typedef struct packed {
    logic [2:0][V_BITS-1:0]    vel;
    logic [2:0][DIFF_BITS-1:0] diff;
    logic [FACT_BITS-1:0]      area;
    logic [FACT_BITS-1:0]      len;
  } front_t;

  typedef struct packed {
    logic [2:0][V_BITS-1:0] vel;
    logic [2:0][D_BITS-1:0] dir;
    logic [FACT_BITS-1:0]   area;
    logic [FACT_BITS-1:0]   len;
    logic                   zero;
  } entry_t;

  typedef struct packed {
    logic                 q_bit;
    logic [DD_BITS-1:0]   rem;
  } div_res_t;

  function automatic div_res_t div_step(input logic [DD_BITS-1:0] rem,
                                        input logic               nb,
                                        input logic [DD_BITS-1:0] dd);
    logic [DD_BITS:0] trial;
    div_res_t         res;
    trial = {rem, nb};
    if (trial >= {1'b0, dd}) begin
      res.q_bit = 1'b1;
      res.rem   = DD_BITS'(trial - {1'b0, dd});
    end else begin
      res.q_bit = 1'b0;
      res.rem   = trial[DD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/segment_anisotropic_drag_top.sv =====
// Drag force increment on a bead past a fibre segment, all signed Q16.16. One item is
// taken per clock and one result leaves per clock when neither side stalls. Accepted
// items pass the front, the four-entry queue and the back pipeline, whose two
// bit-per-stage dividers hold 53 stages for the projection quotient v.d / d.d and
// 20 stages per lane for the remainder term. A stall at the output freezes the back
// pipeline; the front keeps filling the queue until it is full. The user must write
// coefficients through the configuration port only while no item is in flight; the
// block itself does not enforce this.
module segment_anisotropic_drag_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item transfer in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  sad_pkg::in_item_t                  in_data_i,
  // result transfer out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sad_pkg::out_item_t                 out_data_o,
  // coefficient writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sad_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [sad_pkg::COEF_BITS-1:0]      cfg_data_i
);
  import sad_pkg::*;

  coef_t  coef_q;
  logic   push, full, pop, empty;
  entry_t front_entry, queue_entry;

  // coefficient writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NORMAL_DRAG:  coef_q.normal  <= cfg_data_i;
        REG_TANGENT_DRAG: coef_q.tangent <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: direction, zero-length check and magnitude reduction
  sad_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (front_entry),
    .full_i     (full)
  );

  // short queue decoupling the front from the back pipeline
  sad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .empty_o (empty)
  );

  // back: projection, dividers, force products, floor and saturation
  sad_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .entry_i     (queue_entry),
    .empty_i     (empty),
    .coef_i      (coef_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/sad_front.sv =====
module sad_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sad_pkg::in_item_t in_data_i,
  output logic              push_o,
  output sad_pkg::entry_t   entry_o,
  input  logic              full_i
);
  import sad_pkg::*;

  logic   adv;
  logic   f1_valid_q, f2_valid_q;
  front_t f1_q, f1_d;
  entry_t f2_q, f2_d;

  logic [2:0]                neg;
  logic [2:0][DIFF_BITS-1:0] mag;
  logic [2:0][DIR_LIMIT_BITS-1:0] red;
  logic [DIFF_BITS-1:0]      m01, m;
  logic [SHIFT_BITS-1:0]     sh;

  assign adv        = !f2_valid_q || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = f2_valid_q && !full_i;
  assign entry_o    = f2_q;

  // segment direction a - b
  always_comb begin
    f1_d.vel[0] = in_data_i.vel_x;
    f1_d.vel[1] = in_data_i.vel_y;
    f1_d.vel[2] = in_data_i.vel_z;
    f1_d.diff[0] = DIFF_BITS'($signed(in_data_i.pos_a_x)) - DIFF_BITS'($signed(in_data_i.pos_b_x));
    f1_d.diff[1] = DIFF_BITS'($signed(in_data_i.pos_a_y)) - DIFF_BITS'($signed(in_data_i.pos_b_y));
    f1_d.diff[2] = DIFF_BITS'($signed(in_data_i.pos_a_z)) - DIFF_BITS'($signed(in_data_i.pos_b_z));
    f1_d.area = in_data_i.area_factor;
    f1_d.len  = in_data_i.length_factor;
  end

  // magnitude reduction of the direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = f1_q.diff[i][DIFF_BITS-1];
      mag[i] = neg[i] ? DIFF_BITS'(-f1_q.diff[i]) : f1_q.diff[i];
    end
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    m   = (m01 > mag[2]) ? m01 : mag[2];
    sh  = '0;
    for (int k = 1; k <= MAX_SHIFT; k++) begin
      if (m >= (DIFF_BITS'(1) << (DIR_LIMIT_BITS + k - 1))) begin
        sh = SHIFT_BITS'(k);
      end
    end
    for (int i = 0; i < 3; i++) begin
      red[i]      = DIR_LIMIT_BITS'(mag[i] >> sh);
      f2_d.dir[i] = neg[i] ? D_BITS'(-{1'b0, red[i]}) : {1'b0, red[i]};
    end
    f2_d.vel  = f1_q.vel;
    f2_d.area = f1_q.area;
    f2_d.len  = f1_q.len;
    f2_d.zero = (m == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
    end
  end

endmodule

// ===== sv/sad_queue.sv =====
module sad_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sad_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output sad_pkg::entry_t entry_o,
  output logic            empty_o
);
  import sad_pkg::*;

  entry_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]    count_q;

  assign full_o  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/sad_back.sv =====
module sad_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               pop_o,
  input  sad_pkg::entry_t    entry_i,
  input  logic               empty_i,
  input  sad_pkg::coef_t     coef_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sad_pkg::out_item_t out_data_o
);
  import sad_pkg::*;

  localparam int NSTG = 14 + NUM_BITS + Q2_BITS;
  localparam logic signed [ACC_BITS-1:0] SAT_MAX =
    {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic [2:0][V_BITS-1:0] vel;
    logic [2:0][D_BITS-1:0] dir;
    logic [CN_BITS-1:0]     cn;
    logic [CN_BITS-1:0]     ct;
    logic                   zero;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic                neg;
    logic [DD_BITS-1:0]  dd;
    logic [DD_BITS-1:0]  rem;
    logic [NUM_BITS-1:0] num;
    logic [NUM_BITS-1:0] quo;
  } div1_t;

  typedef struct packed {
    side_t                    side;
    logic [DD_BITS-1:0]       dd;
    logic [2:0][PT_BITS-1:0]  qd;
    logic [2:0]               neg;
    logic [2:0][DD_BITS-1:0]  rem;
    logic [2:0][Q2_BITS-1:0]  low;
    logic [2:0][Q2_BITS-1:0]  quo;
  } div2_t;

  typedef struct packed {
    logic [PP_HH_BITS-1:0] hh;
    logic [PP_HL_BITS-1:0] hl;
    logic [PP_LH_BITS-1:0] lh;
    logic [PP_LL_BITS-1:0] ll;
  } pp_t;

  logic            en;
  logic [NSTG-1:0] vld_q;

  side_t                    side0_q, side0_d;
  logic [2:0][PVD_BITS-1:0] pvd0_q, pvd0_d;
  logic [2:0][PDD_BITS-1:0] pdd0_q, pdd0_d;
  side_t                    side1_q;
  logic [VD_BITS-1:0]       vd1_q, vd1_d;
  logic [DD_BITS-1:0]       dd1_q, dd1_d;
  div1_t                    dv1_q [NUM_BITS+1];
  div1_t                    s2_d;
  side_t                    side3_q;
  logic [DD_BITS-1:0]       dd3_q;
  logic [PT_BITS-1:0]       qs3_q, qs3_d;
  logic [RS_BITS-1:0]       rs3_q, rs3_d;
  side_t                    side4_q;
  logic [DD_BITS-1:0]       dd4_q;
  logic [2:0][PT_BITS-1:0]  qd4_q, qd4_d;
  logic [2:0][RD_BITS-1:0]  rd4_q, rd4_d;
  logic [2:0][RDMAG_BITS-1:0] rdmag;
  div2_t                    dv2_q [Q2_BITS+1];
  div2_t                    s5_d;
  side_t                    side6_q;
  logic [2:0][PT_BITS-1:0]  qd6_q;
  logic [2:0][D_BITS-1:0]   q2s6_q, q2s6_d;
  side_t                    side7_q;
  logic [2:0][PT_BITS-1:0]  p7_q, p7_d;
  side_t                    side8_q;
  logic [2:0][PT_BITS-1:0]  p8_q;
  logic [2:0][PT_BITS-1:0]  t8_q, t8_d;
  logic                     zero9_q, zero10_q, zero11_q, zero12_q;
  pp_t  [2:0]               ppn9_q, ppn9_d, ppt9_q, ppt9_d;
  logic [2:0][ACC_BITS-1:0] na10_q, nb10_q, ta10_q, tb10_q;
  logic [2:0][ACC_BITS-1:0] na10_d, nb10_d, ta10_d, tb10_d;
  logic [2:0][ACC_BITS-1:0] n11_q, t11_q, n11_d, t11_d;
  logic [2:0][ACC_BITS-1:0] acc12_q, acc12_d;
  out_item_t                out_q, out_d;
  logic [2:0][ACC_BITS-1:0] shr, sat;
  logic [2:0][OUT_BITS-1:0] frc;

  assign en          = !vld_q[NSTG-1] || !out_stall_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vld_q[NSTG-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], !empty_i};
    end
  end

  // dot products and coefficient scaling
  always_comb begin
    side0_d.vel  = entry_i.vel;
    side0_d.dir  = entry_i.dir;
    side0_d.zero = entry_i.zero;
    side0_d.cn   = CN_BITS'($signed(coef_i.normal) * $signed({1'b0, entry_i.area}));
    side0_d.ct   = CN_BITS'($signed(coef_i.tangent) * $signed({1'b0, entry_i.len}));
    for (int i = 0; i < 3; i++) begin
      pvd0_d[i] = PVD_BITS'($signed(entry_i.vel[i]) * $signed(entry_i.dir[i]));
      pdd0_d[i] = PDD_BITS'($signed(entry_i.dir[i]) * $signed(entry_i.dir[i]));
    end
    vd1_d = VD_BITS'($signed(pvd0_q[0])) + VD_BITS'($signed(pvd0_q[1]))
          + VD_BITS'($signed(pvd0_q[2]));
    dd1_d = DD_BITS'(pdd0_q[0]) + DD_BITS'(pdd0_q[1]) + DD_BITS'(pdd0_q[2]);
    s2_d.side = side1_q;
    s2_d.neg  = vd1_q[VD_BITS-1];
    s2_d.dd   = dd1_q;
    s2_d.rem  = '0;
    s2_d.num  = vd1_q[VD_BITS-1] ? NUM_BITS'(-vd1_q) : vd1_q[NUM_BITS-1:0];
    s2_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q  <= side0_d;
      pvd0_q   <= pvd0_d;
      pdd0_q   <= pdd0_d;
      side1_q  <= side0_q;
      vd1_q    <= vd1_d;
      dd1_q    <= dd1_d;
      dv1_q[0] <= s2_d;
    end
  end

  // first divider: one quotient bit per stage
  for (genvar k = 0; k < NUM_BITS; k++) begin : g_div1
    div_res_t st;
    div1_t    nxt;
    always_comb begin
      st       = div_step(dv1_q[k].rem, dv1_q[k].num[NUM_BITS-1], dv1_q[k].dd);
      nxt      = dv1_q[k];
      nxt.rem  = st.rem;
      nxt.num  = {dv1_q[k].num[NUM_BITS-2:0], 1'b0};
      nxt.quo  = {dv1_q[k].quo[NUM_BITS-2:0], st.q_bit};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv1_q[k+1] <= nxt;
      end
    end
  end

  // signed quotient and remainder, then scale by the direction
  always_comb begin
    qs3_d = dv1_q[NUM_BITS].neg ? PT_BITS'(-dv1_q[NUM_BITS].quo[PT_BITS-1:0])
                                : dv1_q[NUM_BITS].quo[PT_BITS-1:0];
    rs3_d = dv1_q[NUM_BITS].neg ? RS_BITS'(-{1'b0, dv1_q[NUM_BITS].rem})
                                : {1'b0, dv1_q[NUM_BITS].rem};
    for (int i = 0; i < 3; i++) begin
      qd4_d[i] = PT_BITS'($signed(qs3_q) * $signed(side3_q.dir[i]));
      rd4_d[i] = RD_BITS'($signed(rs3_q) * $signed(side3_q.dir[i]));
      rdmag[i] = rd4_q[i][RD_BITS-1] ? RDMAG_BITS'(-rd4_q[i]) : rd4_q[i][RDMAG_BITS-1:0];
      s5_d.neg[i] = rd4_q[i][RD_BITS-1];
      s5_d.rem[i] = rdmag[i][RDMAG_BITS-1:Q2_BITS];
      s5_d.low[i] = rdmag[i][Q2_BITS-1:0];
      s5_d.quo[i] = '0;
    end
    s5_d.side = side4_q;
    s5_d.dd   = dd4_q;
    s5_d.qd   = qd4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q  <= dv1_q[NUM_BITS].side;
      dd3_q    <= dv1_q[NUM_BITS].dd;
      qs3_q    <= qs3_d;
      rs3_q    <= rs3_d;
      side4_q  <= side3_q;
      dd4_q    <= dd3_q;
      qd4_q    <= qd4_d;
      rd4_q    <= rd4_d;
      dv2_q[0] <= s5_d;
    end
  end

  // second divider, three lanes, quotient known to fit Q2_BITS
  for (genvar k = 0; k < Q2_BITS; k++) begin : g_div2
    div_res_t [2:0] st;
    div2_t          nxt;
    always_comb begin
      nxt = dv2_q[k];
      for (int i = 0; i < 3; i++) begin
        st[i] = div_step(dv2_q[k].rem[i], dv2_q[k].low[i][Q2_BITS-1], dv2_q[k].dd);
        nxt.rem[i] = st[i].rem;
        nxt.low[i] = {dv2_q[k].low[i][Q2_BITS-2:0], 1'b0};
        nxt.quo[i] = {dv2_q[k].quo[i][Q2_BITS-2:0], st[i].q_bit};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv2_q[k+1] <= nxt;
      end
    end
  end

  // projection, tangential remainder, partial products and their sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q2s6_d[i] = dv2_q[Q2_BITS].neg[i] ? D_BITS'(-{1'b0, dv2_q[Q2_BITS].quo[i]})
                                         : {1'b0, dv2_q[Q2_BITS].quo[i]};
      p7_d[i] = qd6_q[i] + PT_BITS'($signed(q2s6_q[i]));
      t8_d[i] = PT_BITS'($signed(side7_q.vel[i])) - p7_q[i];
      ppn9_d[i].hh = PP_HH_BITS'($signed(side8_q.cn[CN_BITS-1:C_LO_BITS])
                   * $signed(p8_q[i][PT_BITS-1:P_LO_BITS]));
      ppn9_d[i].hl = PP_HL_BITS'($signed(side8_q.cn[CN_BITS-1:C_LO_BITS])
                   * $signed({1'b0, p8_q[i][P_LO_BITS-1:0]}));
      ppn9_d[i].lh = PP_LH_BITS'($signed({1'b0, side8_q.cn[C_LO_BITS-1:0]})
                   * $signed(p8_q[i][PT_BITS-1:P_LO_BITS]));
      ppn9_d[i].ll = PP_LL_BITS'(side8_q.cn[C_LO_BITS-1:0] * p8_q[i][P_LO_BITS-1:0]);
      ppt9_d[i].hh = PP_HH_BITS'($signed(side8_q.ct[CN_BITS-1:C_LO_BITS])
                   * $signed(t8_q[i][PT_BITS-1:P_LO_BITS]));
      ppt9_d[i].hl = PP_HL_BITS'($signed(side8_q.ct[CN_BITS-1:C_LO_BITS])
                   * $signed({1'b0, t8_q[i][P_LO_BITS-1:0]}));
      ppt9_d[i].lh = PP_LH_BITS'($signed({1'b0, side8_q.ct[C_LO_BITS-1:0]})
                   * $signed(t8_q[i][PT_BITS-1:P_LO_BITS]));
      ppt9_d[i].ll = PP_LL_BITS'(side8_q.ct[C_LO_BITS-1:0] * t8_q[i][P_LO_BITS-1:0]);
      na10_d[i] = (ACC_BITS'($signed(ppn9_q[i].hh)) <<< (C_LO_BITS + P_LO_BITS))
                + (ACC_BITS'($signed(ppn9_q[i].hl)) <<< C_LO_BITS);
      nb10_d[i] = (ACC_BITS'($signed(ppn9_q[i].lh)) <<< P_LO_BITS)
                + ACC_BITS'(ppn9_q[i].ll);
      ta10_d[i] = (ACC_BITS'($signed(ppt9_q[i].hh)) <<< (C_LO_BITS + P_LO_BITS))
                + (ACC_BITS'($signed(ppt9_q[i].hl)) <<< C_LO_BITS);
      tb10_d[i] = (ACC_BITS'($signed(ppt9_q[i].lh)) <<< P_LO_BITS)
                + ACC_BITS'(ppt9_q[i].ll);
      n11_d[i]   = na10_q[i] + nb10_q[i];
      t11_d[i]   = ta10_q[i] + tb10_q[i];
      acc12_d[i] = n11_q[i] + t11_q[i];
    end
  end

  // floor to the output fraction, saturate, zero the force for a zero-length segment
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr[i] = ACC_BITS'($signed(acc12_q[i]) >>> (2 * FRAC_BITS));
      if ($signed(shr[i]) > SAT_MAX) begin
        sat[i] = SAT_MAX;
      end else if ($signed(shr[i]) < SAT_MIN) begin
        sat[i] = SAT_MIN;
      end else begin
        sat[i] = shr[i];
      end
      frc[i] = zero12_q ? '0 : sat[i][OUT_BITS-1:0];
    end
    out_d.force_x     = frc[0];
    out_d.force_y     = frc[1];
    out_d.force_z     = frc[2];
    out_d.zero_length = zero12_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side6_q  <= dv2_q[Q2_BITS].side;
      qd6_q    <= dv2_q[Q2_BITS].qd;
      q2s6_q   <= q2s6_d;
      side7_q  <= side6_q;
      p7_q     <= p7_d;
      side8_q  <= side7_q;
      p8_q     <= p7_q;
      t8_q     <= t8_d;
      zero9_q  <= side8_q.zero;
      ppn9_q   <= ppn9_d;
      ppt9_q   <= ppt9_d;
      zero10_q <= zero9_q;
      na10_q   <= na10_d;
      nb10_q   <= nb10_d;
      ta10_q   <= ta10_d;
      tb10_q   <= tb10_d;
      zero11_q <= zero10_q;
      n11_q    <= n11_d;
      t11_q    <= t11_d;
      zero12_q <= zero11_q;
      acc12_q  <= acc12_d;
      out_q    <= out_d;
    end
  end

endmodule

// ===== dv/segment_anisotropic_drag_top_tb.sv =====
module segment_anisotropic_drag_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sad_pkg::*;

  localparam int FRAC_BITS = 16;

  // drag predictor and the queue of forces still owed by the block
  class drag_scoreboard;
    logic [COEF_BITS-1:0] coef_normal;
    logic [COEF_BITS-1:0] coef_tangent;
    out_item_t            owed_forces[$];
    int                   errors;

    function new();
      coef_normal  = '0;
      coef_tangent = '0;
      errors       = 0;
    endfunction

    function int pending();
      return owed_forces.size();
    endfunction

    function out_item_t predict_force(in_item_t it);
      out_item_t            res;
      longint               vel[3];
      longint               dir[3];
      longint               mag, big, vd, dd, quo, rem, along, cn, ct;
      int                   sh;
      logic signed [127:0]  acc;
      logic [OUT_BITS-1:0]  forces[3];
      vel[0] = longint'($signed(it.vel_x));
      vel[1] = longint'($signed(it.vel_y));
      vel[2] = longint'($signed(it.vel_z));
      dir[0] = longint'($signed(it.pos_a_x)) - longint'($signed(it.pos_b_x));
      dir[1] = longint'($signed(it.pos_a_y)) - longint'($signed(it.pos_b_y));
      dir[2] = longint'($signed(it.pos_a_z)) - longint'($signed(it.pos_b_z));
      big = 0;
      for (int i = 0; i < 3; i++) begin
        mag = dir[i] < 0 ? -dir[i] : dir[i];
        if (mag > big) big = mag;
      end
      res = '0;
      if (big == 0) begin
        res.zero_length = 1'b1;
        return res;
      end
      // shrink the direction so its largest component stays under the limit
      sh = 0;
      while ((big >> sh) >= (longint'(1) << DIR_LIMIT_BITS)) sh++;
      for (int i = 0; i < 3; i++) begin
        mag    = dir[i] < 0 ? -dir[i] : dir[i];
        dir[i] = dir[i] < 0 ? -(mag >> sh) : (mag >> sh);
      end
      vd  = vel[0] * dir[0] + vel[1] * dir[1] + vel[2] * dir[2];
      dd  = dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2];
      quo = vd / dd;
      rem = vd % dd;
      cn  = longint'($signed(coef_normal)) * longint'(it.area_factor);
      ct  = longint'($signed(coef_tangent)) * longint'(it.length_factor);
      for (int i = 0; i < 3; i++) begin
        along = quo * dir[i] + (rem * dir[i]) / dd;
        acc   = 128'(cn) * 128'(along) + 128'(ct) * 128'(vel[i] - along);
        acc   = acc >>> (2 * FRAC_BITS);
        if (acc > 128'sd2147483647)
          forces[i] = 32'h7fff_ffff;
        else if (acc < -128'sd2147483648)
          forces[i] = 32'h8000_0000;
        else
          forces[i] = acc[OUT_BITS-1:0];
      end
      res.force_x = forces[0];
      res.force_y = forces[1];
      res.force_z = forces[2];
      return res;
    endfunction

    function void note_segment(in_item_t it);
      owed_forces.push_back(predict_force(it));
    endfunction

    function void check_force(out_item_t got);
      out_item_t exp_f;
      if (owed_forces.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_f = owed_forces.pop_front();
      if (got.force_x !== exp_f.force_x) begin
        $error("force_x exp %h got %h", exp_f.force_x, got.force_x);
        errors++;
      end
      if (got.force_y !== exp_f.force_y) begin
        $error("force_y exp %h got %h", exp_f.force_y, got.force_y);
        errors++;
      end
      if (got.force_z !== exp_f.force_z) begin
        $error("force_z exp %h got %h", exp_f.force_z, got.force_z);
        errors++;
      end
      if (got.zero_length !== exp_f.zero_length) begin
        $error("zero_length exp %b got %b", exp_f.zero_length, got.zero_length);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 150;  // pipeline and queue depth, with margin

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [COEF_BITS-1:0]  cfg_data_i = '0;

  drag_scoreboard drag_sb = new();
  int             idle_cycles = 0;
  bit             no_gaps = 1'b0;  // stretch with both sides running flat out

  segment_anisotropic_drag_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // monitor: every transfer in either direction, plus the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        drag_sb.note_segment(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        drag_sb.check_force(out_data_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("segment_anisotropic_drag_top_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stall before each result, none during the flat-out stretch
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_NORMAL_DRAG) drag_sb.coef_normal = val;
    else drag_sb.coef_tangent = val;
  endtask

  // let the block drain fully before touching the coefficients
  task automatic drain_pipe();
    while (drag_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_segment(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 1) ? 32'($urandom_range(0, 4095))
                                           : -32'($urandom_range(0, 4095));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_segment();
    in_item_t it;
    logic [31:0] span;
    it.vel_x = rand_word();
    it.vel_y = rand_word();
    it.vel_z = rand_word();
    it.pos_b_x = $urandom;
    it.pos_b_y = $urandom;
    it.pos_b_z = $urandom;
    case ($urandom_range(0, 9))
      // far apart ends: the direction gets shifted down
      0, 1, 2: begin
        it.pos_a_x = $urandom;
        it.pos_a_y = $urandom;
        it.pos_a_z = $urandom;
      end
      // coincident ends
      3: begin
        it.pos_a_x = it.pos_b_x;
        it.pos_a_y = it.pos_b_y;
        it.pos_a_z = it.pos_b_z;
      end
      // short segment, often at the reduction boundary
      default: begin
        span = $urandom_range(0, 1) ? 32'(1 << $urandom_range(0, 21)) : 32'($urandom_range(0, 2000));
        it.pos_a_x = it.pos_b_x + ($urandom_range(0, 1) ? span : -span);
        it.pos_a_y = it.pos_b_y + 32'($urandom_range(0, 3)) - 32'd1;
        it.pos_a_z = it.pos_b_z + ($urandom_range(0, 1) ? 32'($urandom_range(0, 300)) : 32'd0);
      end
    endcase
    it.area_factor   = $urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
    it.length_factor = $urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
    return it;
  endfunction

  task automatic run_directed();
    in_item_t it;
    // zero-length segment at the origin and at the most negative x
    it = '0;
    it.vel_x = 32'h7fff_ffff;
    it.area_factor = '1;
    it.length_factor = '1;
    send_segment(it);
    it.pos_a_x = 32'h8000_0000; it.pos_b_x = 32'h8000_0000;
    send_segment(it);
    // longest possible direction, all fields at extremes
    it = '1;
    it.pos_a_x = 32'h7fff_ffff; it.pos_b_x = 32'h8000_0000;
    it.pos_a_y = 32'h8000_0000; it.pos_b_y = 32'h7fff_ffff;
    it.pos_a_z = 32'h7fff_ffff; it.pos_b_z = 32'h8000_0000;
    it.vel_x = 32'h8000_0000; it.vel_y = 32'h7fff_ffff; it.vel_z = 32'h8000_0000;
    send_segment(it);
    // velocity along the segment, then across it
    it = '0;
    it.pos_a_x = 32'h0001_0000;
    it.vel_x = 32'h0003_0000;
    it.area_factor = 31'h1_0000;
    it.length_factor = 31'h1_0000;
    send_segment(it);
    it.vel_x = '0; it.vel_y = 32'hfffd_0000;
    send_segment(it);
    // direction just below and just at the reduction limit
    it.vel_x = 32'h1234_5678; it.vel_z = 32'h8765_4321;
    it.pos_a_x = 32'h000f_ffff;
    send_segment(it);
    it.pos_a_x = 32'h0010_0000;
    send_segment(it);
    it.pos_a_x = 32'hfff0_0000; it.pos_a_y = 32'h0000_0007;
    send_segment(it);
    // unit direction along each axis with a negative sign
    for (int k = 0; k < 3; k++) begin
      it = '0;
      it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom;
      it.area_factor = '1; it.length_factor = '1;
      if (k == 0) it.pos_b_x = 32'd1;
      else if (k == 1) it.pos_b_y = 32'd1;
      else it.pos_b_z = 32'd1;
      send_segment(it);
    end
  endtask

  initial begin
    logic [COEF_BITS-1:0] coef_sets[6][2];
    coef_sets = '{'{32'h0001_0000, 32'h0000_8000}, '{32'h7fff_ffff, 32'h8000_0000},
                  '{32'h8000_0000, 32'h7fff_ffff}, '{32'h0, 32'hffff_0000},
                  '{32'h0, 32'h0}, '{32'h0, 32'h0}};
    coef_sets[4][0] = $urandom;
    coef_sets[4][1] = $urandom;
    coef_sets[5][0] = $urandom_range(0, 1 << 20);
    coef_sets[5][1] = -$urandom_range(0, 1 << 20);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients are zero: every force is zero
    run_directed();
    for (int ph = 0; ph < 6; ph++) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      drain_pipe();
      write_coef(REG_NORMAL_DRAG, coef_sets[ph][0]);
      write_coef(REG_TANGENT_DRAG, coef_sets[ph][1]);
      if (ph < 2) run_directed();
      for (int n = 0; n < 260; n++) begin
        no_gaps = (n >= 100 && n < 140);
        // sender holds off until the block has emptied
        if (n == 200) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (drag_sb.pending() != 0) @(posedge clk_i);
        end
        send_segment(rand_segment());
      end
      no_gaps = 1'b0;
    end
    in_valid_i <= 1'b0;

    drain_pipe();
    if (drag_sb.errors == 0 && drag_sb.pending() == 0)
      $display("segment_anisotropic_drag_top_tb: done, clean");
    else
      $display("segment_anisotropic_drag_top_tb: done, errors");
    $finish;
  end

endmodule
